// ===== hw/rtl/lrpg_pkg.sv =====
// Shared types, constants and tables for the logistic ramp profile generator.
// No dependencies.
`timescale 1ns / 1ps

package lrpg_pkg;

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,
        PH_HOLD = 2'd1,
        PH_FALL = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    localparam int FRAC_BITS  = 16;
    localparam int VALUE_W    = 16;
    localparam int RAMP_W     = 20;
    localparam int HOURS_W    = 12;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int QUO_W      = 17;
    localparam int Y_W        = 19;
    localparam int E_W        = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN = 2'd3;

    // log2(99) in Q16
    localparam logic [Y_W-1:0] LOG2_99_Q16 = 19'd434462;

    // 2^(-k/16) in Q1.16, k = 0..16
    function automatic logic [E_W-1:0] exp2_tab(input logic [4:0] k);
        logic [E_W-1:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic take;
        logic skip;
        logic prep;
        logic exp1;
        logic exp2;
        logic load2;
        logic mul;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic ramp;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/lrpg_div.sv =====
// Restoring divider, 17 quotient bits, one bit per cycle.
// Depends on lrpg_pkg.
`timescale 1ns / 1ps

module lrpg_div #(
    parameter int W = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_num_hi,
    input  logic [lrpg_pkg::QUO_W-1:0]  i_num_lo,
    input  logic [W-1:0]                i_den,
    output logic [lrpg_pkg::QUO_W-1:0]  o_quo,
    output logic                        o_done
);

    localparam int QW = lrpg_pkg::QUO_W;

    logic          r_busy, n_busy;
    logic [4:0]    r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den, n_den;
    logic [QW-1:0] r_lo, n_lo;
    logic [QW-1:0] r_quo, n_quo;
    logic          r_done, n_done;
    logic [W:0]    trial;
    logic          fits;

    always_comb begin
        trial = {r_rem, r_lo[QW-1]};
        fits  = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_lo   = r_lo;
        n_quo  = r_quo;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num_hi;
            n_den  = i_den;
            n_lo   = i_num_lo;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = fits ? W'(trial - {1'b0, r_den}) : trial[W-1:0];
            n_quo = {r_quo[QW-2:0], fits};
            n_lo  = {r_lo[QW-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_lo  <= n_lo;
        r_quo <= n_quo;
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/lrpg_ctrl.sv =====
// Sequencing state machine: input handshake and datapath commands.
// Depends on lrpg_pkg.
`timescale 1ns / 1ps

module lrpg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lrpg_pkg::t_sts i_sts,
    output lrpg_pkg::t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_SKIP = 10'b0000000010,
        S_PREP = 10'b0000000100,
        S_DIV1 = 10'b0000001000,
        S_EXP1 = 10'b0000010000,
        S_EXP2 = 10'b0000100000,
        S_LD2  = 10'b0001000000,
        S_DIV2 = 10'b0010000000,
        S_MUL  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SKIP;
                end
            end
            S_SKIP: begin
                o_cmd.skip = 1'b1;
                n_state    = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.ramp ? S_DIV1 : S_FIN;
            end
            S_DIV1: begin
                if (i_sts.div_done) n_state = S_EXP1;
            end
            S_EXP1: begin
                o_cmd.exp1 = 1'b1;
                n_state    = S_EXP2;
            end
            S_EXP2: begin
                o_cmd.exp2 = 1'b1;
                n_state    = S_LD2;
            end
            S_LD2: begin
                o_cmd.load2 = 1'b1;
                n_state     = S_DIV2;
            end
            S_DIV2: begin
                if (i_sts.div_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/lrpg_dp.sv =====
// Datapath: configuration, phase position, sigmoid arithmetic, output register.
// Depends on lrpg_pkg and lrpg_div.
`timescale 1ns / 1ps

module lrpg_dp #(
    parameter int SAMPLES_PER_HOUR = 3600,
    parameter int COUNTER_BITS     = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lrpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_restart,
    input  lrpg_pkg::t_cmd                      i_cmd,
    output lrpg_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lrpg_pkg::VALUE_W-1:0]        o_sample_value,
    output logic [1:0]                          o_phase_code,
    output logic                                o_last_sample
);

    localparam int DW    = COUNTER_BITS + 1;
    localparam int DVW   = (DW > 18) ? DW : 18;
    localparam int SPH_W = $clog2(SAMPLES_PER_HOUR + 1);
    localparam int HLW   = lrpg_pkg::HOURS_W + SPH_W;
    localparam int PW0   = (HLW > lrpg_pkg::RAMP_W) ? HLW : lrpg_pkg::RAMP_W;
    localparam int PW    = ((PW0 > DW) ? PW0 : DW) + 1;
    localparam int VW    = lrpg_pkg::VALUE_W;
    localparam int QW    = lrpg_pkg::QUO_W;
    localparam int EW    = lrpg_pkg::E_W;
    localparam int YW    = lrpg_pkg::Y_W;
    localparam int FB    = lrpg_pkg::FRAC_BITS;

    typedef struct packed {
        lrpg_pkg::t_phase ph;
        logic [DW-1:0]    cnt;
    } t_pos;

    function automatic t_pos f_skip(input t_pos p, input logic [DW-1:0] lr,
                                    input logic [DW-1:0] lh, input logic [DW-1:0] lf);
        t_pos q;
        q = p;
        if (q.ph == lrpg_pkg::PH_RISE && q.cnt >= lr) begin
            q.ph  = lrpg_pkg::PH_HOLD;
            q.cnt = '0;
        end
        if (q.ph == lrpg_pkg::PH_HOLD && q.cnt >= lh) begin
            q.ph  = lrpg_pkg::PH_FALL;
            q.cnt = '0;
        end
        if (q.ph == lrpg_pkg::PH_FALL && q.cnt >= lf) begin
            q.ph  = lrpg_pkg::PH_DONE;
            q.cnt = '0;
        end
        return q;
    endfunction

    logic [VW-1:0]                  r_height;
    logic [lrpg_pkg::RAMP_W-1:0]    r_ramp_up;
    logic [lrpg_pkg::HOURS_W-1:0]   r_hold;
    logic [lrpg_pkg::RAMP_W-1:0]    r_ramp_dn;
    lrpg_pkg::t_phase               r_phase;
    logic [DW-1:0]                  r_cnt;
    logic                           r_restart;
    logic                           r_neg;
    logic [YW-1:0]                  r_y;
    logic [EW-1:0]                  r_e;
    logic [VW-1:0]                  r_val;
    logic                           r_out_valid;
    logic [VW-1:0]                  r_out_value;
    logic [1:0]                     r_out_phase;
    logic                           r_out_last;

    logic [PW-1:0]  cap, raw_up, raw_hold, raw_dn;
    logic [DW-1:0]  len_up, len_hold, len_dn, d;
    t_pos           pos0, pos_start, pos_inc;
    logic           rise, ramp;
    logic [DW:0]    two_t, dd, adiff;
    logic [DW-1:0]  a;
    logic           ge, neg;
    logic           div_start, div_done;
    logic [DVW-1:0] div_hi, div_den;
    logic [QW-1:0]  div_lo, quo;
    logic [35:0]    y_prod;
    logic [3:0]     ti_idx;
    logic [EW-1:0]  ti, ti1, tdiff, m, e;
    logic [28:0]    interp;
    logic [VW-1:0]  s_sat;
    logic [31:0]    v_prod;
    logic           out_free;

    always_comb begin
        cap      = PW'(1) << COUNTER_BITS;
        raw_up   = PW'(r_ramp_up);
        raw_dn   = PW'(r_ramp_dn);
        raw_hold = PW'(r_hold) * PW'(SAMPLES_PER_HOUR);
        len_up   = (raw_up > cap) ? DW'(cap) : DW'(raw_up);
        len_dn   = (raw_dn > cap) ? DW'(cap) : DW'(raw_dn);
        len_hold = (raw_hold > cap) ? DW'(cap) : DW'(raw_hold);

        pos0.ph   = r_restart ? lrpg_pkg::PH_RISE : r_phase;
        pos0.cnt  = r_restart ? '0 : r_cnt;
        pos_start = f_skip(pos0, len_up, len_hold, len_dn);
        pos_inc   = f_skip('{ph: r_phase, cnt: r_cnt + DW'(1)}, len_up, len_hold, len_dn);

        rise  = (r_phase == lrpg_pkg::PH_RISE);
        ramp  = rise || (r_phase == lrpg_pkg::PH_FALL);
        d     = rise ? len_up : len_dn;
        two_t = {r_cnt, 1'b0};
        dd    = {1'b0, d};
        ge    = (two_t >= dd);
        adiff = ge ? (two_t - dd) : (dd - two_t);
        a     = adiff[DW-1:0];
        neg   = rise ? !ge : (two_t > dd);

        div_start = (i_cmd.prep && ramp) || i_cmd.load2;
        if (i_cmd.prep) begin
            div_hi  = DVW'(a >> 1);
            div_lo  = {a[0], {FB{1'b0}}};
            div_den = DVW'(d);
        end else begin
            div_den = DVW'({1'b0, r_e} + 18'd65536);
            div_hi  = r_neg ? DVW'(r_e >> 1) : DVW'(18'd32768);
            div_lo  = r_neg ? {r_e[0], {FB{1'b0}}} : '0;
        end

        y_prod = 36'(quo) * 36'(lrpg_pkg::LOG2_99_Q16);

        ti_idx = r_y[15:12];
        ti     = lrpg_pkg::exp2_tab({1'b0, ti_idx});
        ti1    = lrpg_pkg::exp2_tab(5'({1'b0, ti_idx}) + 5'd1);
        tdiff  = ti - ti1;
        interp = 29'(tdiff) * 29'(r_y[11:0]);
        m      = ti - EW'(interp >> 12);
        e      = m >> r_y[18:16];

        s_sat  = quo[QW-1] ? {VW{1'b1}} : quo[VW-1:0];
        v_prod = 32'(r_height) * 32'(s_sat);

        out_free = !r_out_valid || !i_out_stall;
    end

    lrpg_div #(.W(DVW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num_hi (div_hi),
        .i_num_lo (div_lo),
        .i_den    (div_den),
        .o_quo    (quo),
        .o_done   (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= '0;
            r_ramp_up   <= '0;
            r_hold      <= '0;
            r_ramp_dn   <= '0;
            r_phase     <= lrpg_pkg::PH_DONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lrpg_pkg::CFG_HEIGHT:    r_height  <= i_cfg_data[VW-1:0];
                    lrpg_pkg::CFG_RAMP_UP:   r_ramp_up <= i_cfg_data;
                    lrpg_pkg::CFG_HOLD:      r_hold    <= i_cfg_data[lrpg_pkg::HOURS_W-1:0];
                    lrpg_pkg::CFG_RAMP_DOWN: r_ramp_dn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.skip) begin
                r_phase <= pos_start.ph;
                r_cnt   <= pos_start.cnt;
            end else if (i_cmd.fin && r_phase != lrpg_pkg::PH_DONE) begin
                r_phase <= pos_inc.ph;
                r_cnt   <= pos_inc.cnt;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.take) r_restart <= i_restart;
        if (i_cmd.prep) r_neg <= neg;
        if (i_cmd.exp1) r_y <= y_prod[FB+YW-1:FB];
        if (i_cmd.exp2) r_e <= e;
        if (i_cmd.mul)  r_val <= v_prod[31:16];
        if (i_cmd.fin) begin
            if (r_phase == lrpg_pkg::PH_DONE) begin
                r_out_value <= '0;
                r_out_phase <= lrpg_pkg::PH_DONE;
                r_out_last  <= 1'b0;
            end else begin
                r_out_value <= (r_phase == lrpg_pkg::PH_HOLD) ? r_height : r_val;
                r_out_phase <= r_phase;
                r_out_last  <= (pos_inc.ph == lrpg_pkg::PH_DONE);
            end
        end
    end

    assign o_sts.ramp     = ramp;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_phase_code   = r_out_phase;
    assign o_last_sample  = r_out_last;

endmodule

// ===== hw/rtl/logistic_ramp_profile_generator.sv =====
// Top level of the logistic ramp/hold/ramp profile generator.
// Depends on lrpg_pkg, lrpg_ctrl, lrpg_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_restart): each transfer
//   is one tick. i_restart = 1 starts the profile over at its first sample.
//   Output channel (o_out_valid / i_out_stall): one result per tick with the
//   sample value, phase code and a flag on the last sample of the profile.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data): 0 height, 1 ramp-up
//   seconds, 2 hold hours, 3 ramp-down seconds; write only while idle.
// Timing:
//   One tick at a time. A ramp sample's time from input transfer to output
//   valid is set by two passes through the 17-step serial divider (ramp
//   ratio, then the sigmoid reciprocal); hold and done samples bypass the
//   divider. The next tick is taken once the result sits in the output
//   register.
// Reset: synchronous, active low; config registers clear to 0, the profile
//   sits in the done phase until a restart. A stalled output holds its
//   result and the block waits at the end of the next tick until it is taken.
`timescale 1ns / 1ps

module logistic_ramp_profile_generator #(
    parameter int SAMPLES_PER_HOUR = 3600,
    parameter int COUNTER_BITS     = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lrpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lrpg_pkg::VALUE_W-1:0]        o_sample_value,
    output logic [1:0]                          o_phase_code,
    output logic                                o_last_sample
);

    lrpg_pkg::t_cmd cmd;
    lrpg_pkg::t_sts sts;

    lrpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lrpg_dp #(
        .SAMPLES_PER_HOUR (SAMPLES_PER_HOUR),
        .COUNTER_BITS     (COUNTER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_restart      (i_restart),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value),
        .o_phase_code   (o_phase_code),
        .o_last_sample  (o_last_sample)
    );

endmodule

// ===== hw/rtl/lrpg_chk.sv =====
// Port-level checker for the profile generator, bound to the top level.
// Depends on lrpg_pkg.
`timescale 1ns / 1ps

module lrpg_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [lrpg_pkg::VALUE_W-1:0]  o_sample_value,
    input logic [1:0]                    o_phase_code,
    input logic                          o_last_sample
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output dropped while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase_code == lrpg_pkg::PH_DONE |->
            o_sample_value == '0 && !o_last_sample)
        else $error("done result not zero");

    a_no_out_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result shown before its tick was processed");

endmodule

bind logistic_ramp_profile_generator lrpg_chk u_lrpg_chk (.*);

// ===== verif/tb_logistic_ramp_profile_generator.sv =====
// Testbench for the logistic ramp profile generator: drives restart/advance ticks,
// predicts each sample with an independent fixed-point sigmoid model and checks results.
// Depends on lrpg_pkg and logistic_ramp_profile_generator.
`timescale 1ns / 1ps

module tb_logistic_ramp_profile_generator;

    localparam int HOUR_SAMPLES = 3600;
    localparam int CNT_BITS     = 24;

    typedef struct {
        logic [lrpg_pkg::VALUE_W-1:0] value;
        lrpg_pkg::t_phase             phase;
        logic                         last;
    } t_sample;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [lrpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx = lrpg_pkg::CFG_HEIGHT;
    logic [lrpg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_restart = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [lrpg_pkg::VALUE_W-1:0]    o_sample_value;
    logic [1:0]                      o_phase_code;
    logic                            o_last_sample;

    logistic_ramp_profile_generator i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and shadow registers
    logic [15:0]          m_height;
    logic [19:0]          m_ramp_up;
    logic [11:0]          m_hold;
    logic [19:0]          m_ramp_down;
    lrpg_pkg::t_phase     m_phase;
    logic [CNT_BITS:0]    m_count;

    bit                   tick_queue[$];
    t_sample              expected_samples[$];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_off_cycles;
    int                   errors;
    int                   n_samples;
    int                   n_phase_seen[4];

    function automatic longint phase_len(lrpg_pkg::t_phase p);
        longint len;
        case (p)
            lrpg_pkg::PH_RISE: len = longint'(m_ramp_up);
            lrpg_pkg::PH_HOLD: len = longint'(m_hold) * HOUR_SAMPLES;
            lrpg_pkg::PH_FALL: len = longint'(m_ramp_down);
            default: len = 0;
        endcase
        if (len > (longint'(1) << CNT_BITS)) len = longint'(1) << CNT_BITS;
        return len;
    endfunction

    function automatic void skip_empty();
        while (m_phase != lrpg_pkg::PH_DONE && longint'(m_count) >= phase_len(m_phase)) begin
            m_phase = lrpg_pkg::t_phase'(m_phase + 1);
            m_count = '0;
        end
    endfunction

    function automatic longint curve_q16(longint t, longint d, bit falling);
        longint tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        longint u, a, q, y, e, s, n, f, k, r, m;
        u = 2 * t - d;
        if (falling) u = -u;
        a = (u < 0) ? -u : u;
        q = (a << 16) / d;
        y = (q * 434462) >> 16;
        n = y >> 16;
        f = y & 16'hFFFF;
        k = f >> 12;
        r = f & 12'hFFF;
        if (n > 16) e = 0;
        else begin
            m = tab[k] - (((tab[k] - tab[k + 1]) * r) >> 12);
            e = m >> n;
        end
        if (u >= 0) s = (longint'(1) << 32) / (65536 + e);
        else s = (e << 16) / (65536 + e);
        return (s > 65535) ? 65535 : s;
    endfunction

    function automatic t_sample next_sample(bit restart);
        t_sample          res;
        lrpg_pkg::t_phase ph;
        if (restart) begin
            m_phase = lrpg_pkg::PH_RISE;
            m_count = '0;
        end
        skip_empty();
        if (m_phase == lrpg_pkg::PH_DONE) begin
            res.value = '0;
            res.phase = lrpg_pkg::PH_DONE;
            res.last = 1'b0;
            return res;
        end
        ph = m_phase;
        if (ph == lrpg_pkg::PH_HOLD) res.value = m_height;
        else res.value = 16'((longint'(m_height) * curve_q16(longint'(m_count), phase_len(ph),
                                                              ph == lrpg_pkg::PH_FALL)) >> 16);
        res.phase = ph;
        m_count = m_count + 1'b1;
        skip_empty();
        res.last = (m_phase == lrpg_pkg::PH_DONE);
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_restart  <= tick_queue[0];
                expected_samples.push_back(next_sample(tick_queue.pop_front()));
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected transfer: value %0d phase %0d", o_sample_value, o_phase_code);
                errors++;
            end else begin
                exp_s = expected_samples.pop_front();
                n_samples++;
                n_phase_seen[exp_s.phase]++;
                if (o_sample_value !== exp_s.value) begin
                    $error("sample_value: expected %0d, got %0d", exp_s.value, o_sample_value);
                    errors++;
                end
                if (o_phase_code !== exp_s.phase) begin
                    $error("phase_code: expected %0d, got %0d", exp_s.phase, o_phase_code);
                    errors++;
                end
                if (o_last_sample !== exp_s.last) begin
                    $error("last_sample: expected %0d, got %0d", exp_s.last, o_last_sample);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [lrpg_pkg::CFG_IDX_W-1:0] idx,
                             logic [lrpg_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            lrpg_pkg::CFG_HEIGHT:  m_height = data[15:0];
            lrpg_pkg::CFG_RAMP_UP: m_ramp_up = data;
            lrpg_pkg::CFG_HOLD:    m_hold = data[11:0];
            default:               m_ramp_down = data;
        endcase
    endtask

    task automatic set_profile(int h, int up, int hrs, int down);
        write_reg(lrpg_pkg::CFG_HEIGHT, lrpg_pkg::CFG_DATA_W'(h));
        write_reg(lrpg_pkg::CFG_RAMP_UP, lrpg_pkg::CFG_DATA_W'(up));
        write_reg(lrpg_pkg::CFG_HOLD, lrpg_pkg::CFG_DATA_W'(hrs));
        write_reg(lrpg_pkg::CFG_RAMP_DOWN, lrpg_pkg::CFG_DATA_W'(down));
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || expected_samples.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic queue_ticks(int n, int restart_pct);
        repeat (n) tick_queue.push_back($urandom_range(99) < restart_pct);
    endtask

    initial begin
        m_height = '0; m_ramp_up = '0; m_hold = '0; m_ramp_down = '0;
        m_phase = lrpg_pkg::PH_DONE;
        m_count = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: done after reset, empty profile, short ramps, restart mid-profile
        tick_queue = '{0, 1, 0};
        drain();
        set_profile(16'hFFFF, 5, 0, 4);
        tick_queue = '{1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        drain();
        set_profile(0, 1, 0, 1);
        tick_queue = '{1, 0, 0};
        drain();
        set_profile(16'h8001, 0, 1, 0);
        tick_queue = '{1, 0, 1};
        drain();
        // long ramps at the top of the register range
        set_profile(16'hFFFF, 20'hFFFFF, 12'hFFF, 20'hFFFFF);
        tick_queue = '{1, 0, 0, 0};
        drain();

        // random: sender idles rarely, receiver often
        send_idle_pct = 7;
        recv_idle_pct = 83;
        set_profile($urandom, $urandom_range(40), $urandom_range(1), $urandom_range(40));
        queue_ticks(500, 3);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 7;
        set_profile($urandom, $urandom_range(1, 300), 0, $urandom_range(1, 300));
        queue_ticks(500, 1);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_profile($urandom, $urandom_range(20), 0, $urandom_range(20));
        tick_queue.push_back(1'b1);
        queue_ticks(20, 10);
        hold_off_cycles = 400;
        drain();
        set_profile($urandom, $urandom_range(1, 2000), $urandom_range(4095),
                    $urandom_range(1, 2000));
        queue_ticks(500, 5);
        drain();
        repeat (100) @(posedge i_clk);

        $display("Checked %0d samples: rise %0d, hold %0d, fall %0d, done %0d.",
                 n_samples, n_phase_seen[0], n_phase_seen[1], n_phase_seen[2],
                 n_phase_seen[3]);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
